@@ hw/rtl/utd_pkg.sv @@
`timescale 1ns / 1ps
// Types, codes and helper functions shared by the UTF-8 to UCS-2 decoder.
package utd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        char_valid;
      logic        buffer_done;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNCHANGED = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;
   localparam logic [1:0] STATUS_TOO_WIDE  = 2'd3;

   localparam logic [1:0] LEAD_SINGLE = 2'd0;
   localparam logic [1:0] LEAD_DOUBLE = 2'd1;
   localparam logic [1:0] LEAD_TRIPLE = 2'd2;
   localparam logic [1:0] LEAD_BAD    = 2'd3;

   localparam int unsigned SUM_WIDTH  = 20;
   localparam logic [7:0]  LATIN1_MAX = 8'hFF;

   function automatic logic [1:0] lead_extra(input logic [7:0] b);
      logic [1:0] ex;
      if (b < 8'hC0) begin
         ex = LEAD_SINGLE;
      end else if (b < 8'hE0) begin
         ex = LEAD_DOUBLE;
      end else if (b < 8'hF0) begin
         ex = LEAD_TRIPLE;
      end else begin
         ex = LEAD_BAD;
      end
      return ex;
   endfunction

   function automatic logic [SUM_WIDTH-1:0] seq_offset(input logic [1:0] len);
      logic [SUM_WIDTH-1:0] off;
      unique case (len)
         LEAD_DOUBLE: off = 20'h03080;
         LEAD_TRIPLE: off = 20'hE2080;
         default:     off = 20'h00000;
      endcase
      return off;
   endfunction

endpackage

@@ hw/rtl/utd_in_stage.sv @@
`timescale 1ns / 1ps
// Input register stage: holds one transaction until the decode step takes it.
module utd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  utd_pkg::req_type  req_payload,
   input  logic              step,
   output logic              item_valid,
   output utd_pkg::req_type  item
);

   logic             in_valid_ff;
   logic             in_valid_in;
   utd_pkg::req_type in_payload_ff;
   utd_pkg::req_type in_payload_in;

   assign req_stall  = in_valid_ff && !step;
   assign item_valid = in_valid_ff;
   assign item       = in_payload_ff;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_payload_in = in_payload_ff;
      if (!req_stall) begin
         in_valid_in   = req_valid;
         in_payload_in = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_payload_ff <= in_payload_in;
   end

endmodule

@@ hw/rtl/utd_decode.sv @@
`timescale 1ns / 1ps
// Decode step: sequence state, offset subtraction, range check and status.
module utd_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              step,
   input  utd_pkg::req_type  item,
   output logic              result_valid,
   output utd_pkg::rsp_type  result
);

   localparam int unsigned SW = utd_pkg::SUM_WIDTH;

   logic          target_mode_ff;
   logic [SW-1:0] partial_sum_ff;
   logic [SW-1:0] partial_sum_in;
   logic [1:0]    bytes_left_ff;
   logic [1:0]    bytes_left_in;
   logic [1:0]    sequence_length_ff;
   logic [1:0]    sequence_length_in;
   logic          multibyte_seen_ff;
   logic          multibyte_seen_in;
   logic [1:0]    latched_error_ff;
   logic [1:0]    latched_error_in;

   logic [1:0]    ex;
   logic [SW-1:0] acc;
   logic [1:0]    bl_dec;
   logic [SW:0]   diff;
   logic [SW:0]   ch;
   logic          have_char;
   logic          valid;
   logic          latin1;
   logic          last;
   logic [15:0]   code;
   logic [1:0]    st;

   assign latin1 = target_mode_ff;
   assign last   = item.buffer_end;
   assign ex     = utd_pkg::lead_extra(item.data_byte);
   assign acc    = {partial_sum_ff[SW-7:0], 6'b0} + {{(SW-8){1'b0}}, item.data_byte};
   assign bl_dec = bytes_left_ff - 2'd1;
   assign diff   = {1'b0, acc} - {1'b0, utd_pkg::seq_offset(sequence_length_ff)};

   always_comb begin
      partial_sum_in     = partial_sum_ff;
      bytes_left_in      = bytes_left_ff;
      sequence_length_in = sequence_length_ff;
      multibyte_seen_in  = multibyte_seen_ff;
      latched_error_in   = latched_error_ff;
      have_char          = 1'b0;
      valid              = 1'b0;
      ch                 = '0;
      code               = '0;
      st                 = utd_pkg::STATUS_OK;

      if (latched_error_ff == utd_pkg::STATUS_OK) begin
         if (bytes_left_ff == 2'd0) begin
            unique case (ex)
               utd_pkg::LEAD_BAD: begin
                  latched_error_in = utd_pkg::STATUS_MALFORMED;
               end
               utd_pkg::LEAD_SINGLE: begin
                  ch        = {{(SW-7){1'b0}}, item.data_byte};
                  have_char = 1'b1;
               end
               default: begin
                  if (last) begin
                     latched_error_in = utd_pkg::STATUS_MALFORMED;
                  end else begin
                     partial_sum_in     = {{(SW-8){1'b0}}, item.data_byte};
                     bytes_left_in      = ex;
                     sequence_length_in = ex;
                  end
               end
            endcase
         end else begin
            partial_sum_in = acc;
            bytes_left_in  = bl_dec;
            if (bl_dec == 2'd0) begin
               ch                 = diff;
               have_char          = 1'b1;
               multibyte_seen_in  = 1'b1;
               partial_sum_in     = '0;
               sequence_length_in = 2'd0;
            end else if (last) begin
               latched_error_in   = utd_pkg::STATUS_MALFORMED;
               partial_sum_in     = '0;
               bytes_left_in      = 2'd0;
               sequence_length_in = 2'd0;
            end
         end
         if (have_char) begin
            if (latin1 && (ch[SW] || (ch[SW-1:8] != '0))) begin
               latched_error_in = utd_pkg::STATUS_TOO_WIDE;
            end else begin
               valid = 1'b1;
               code  = latin1 ? {8'b0, ch[7:0] & utd_pkg::LATIN1_MAX} : ch[15:0];
            end
         end
      end

      if (last) begin
         if (latched_error_in != utd_pkg::STATUS_OK) begin
            st = latched_error_in;
         end else if (latin1 && !multibyte_seen_in) begin
            st = utd_pkg::STATUS_UNCHANGED;
         end
         partial_sum_in     = '0;
         bytes_left_in      = 2'd0;
         sequence_length_in = 2'd0;
         multibyte_seen_in  = 1'b0;
         latched_error_in   = utd_pkg::STATUS_OK;
      end

      result_valid       = step && (last || valid);
      result.code_unit   = code;
      result.char_valid  = valid;
      result.buffer_done = last;
      result.status      = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_mode_ff     <= 1'b0;
         partial_sum_ff     <= '0;
         bytes_left_ff      <= 2'd0;
         sequence_length_ff <= 2'd0;
         multibyte_seen_ff  <= 1'b0;
         latched_error_ff   <= utd_pkg::STATUS_OK;
      end else begin
         if (csr_write_enable) begin
            target_mode_ff <= csr_write_data;
         end
         if (step) begin
            partial_sum_ff     <= partial_sum_in;
            bytes_left_ff      <= bytes_left_in;
            sequence_length_ff <= sequence_length_in;
            multibyte_seen_ff  <= multibyte_seen_in;
            latched_error_ff   <= latched_error_in;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      result_valid && !result.buffer_done |->
         result.char_valid && (result.status == utd_pkg::STATUS_OK))
      else $error("mid-buffer transaction without a character or with a status");

   assert property (@(posedge clock) disable iff (reset)
      result_valid && !result.char_valid |-> (result.code_unit == 16'd0))
      else $error("code unit not cleared on an empty transaction");

   assert property (@(posedge clock) disable iff (reset)
      step && item.buffer_end |=>
         (bytes_left_ff == 2'd0) && (latched_error_ff == utd_pkg::STATUS_OK)
         && !multibyte_seen_ff && (partial_sum_ff == '0))
      else $error("state not cleared after buffer end");

   assert property (@(posedge clock) disable iff (reset)
      (latched_error_ff != utd_pkg::STATUS_OK) |-> (bytes_left_ff == 2'd0))
      else $error("open sequence alongside a latched error");

   assert property (@(posedge clock) disable iff (reset)
      result_valid && result.char_valid && target_mode_ff |->
         (result.code_unit[15:8] == 8'd0))
      else $error("Latin-1 character wider than eight bits");

endmodule

@@ hw/rtl/utd_out_stage.sv @@
`timescale 1ns / 1ps
// Result register stage: holds one result transaction until the consumer takes it.
module utd_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              result_valid,
   input  utd_pkg::rsp_type  result,
   output logic              ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output utd_pkg::rsp_type  rsp_payload
);

   logic             out_valid_ff;
   logic             out_valid_in;
   utd_pkg::rsp_type out_payload_ff;
   utd_pkg::rsp_type out_payload_in;

   assign ready       = !out_valid_ff || !rsp_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_payload_in = out_payload_ff;
      if (ready) begin
         out_valid_in   = result_valid;
         out_payload_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_payload_ff <= out_payload_in;
   end

endmodule

@@ hw/rtl/utf8_to_ucs2_decoder_unit.sv @@
`timescale 1ns / 1ps
// UTF-8 to UCS-2 / Latin-1 decoder, top level. One byte transaction is taken per cycle
// while req_stall is low; each byte passes through the input register and then the
// result register, with the sequence state updated by the single decode step between
// them. A result is produced when a character completes without error, and always for
// the byte flagged as buffer end; other bytes produce none. The mode register is written
// through csr_write_enable/csr_write_data and takes effect on the next decoded byte.
module utf8_to_ucs2_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  utd_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output utd_pkg::rsp_type  rsp_payload,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   logic             item_valid;
   utd_pkg::req_type item;
   logic             out_ready;
   logic             step;
   logic             result_valid;
   utd_pkg::rsp_type result;

   assign step = item_valid && out_ready;

   utd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .step        (step),
      .item_valid  (item_valid),
      .item        (item)
   );

   utd_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .item             (item),
      .result_valid     (result_valid),
      .result           (result)
   );

   utd_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .ready        (out_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule
